>>> hdl/chfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chfm_pkg
// Shared types and codes for the chunked byte FIFO pointer manager.
// ----------------------------------------------------------------------------
package chfm_pkg;

  // Fixed port field widths
  localparam int unsigned IDX_OUT_W = 3;
  localparam int unsigned LEN_W     = 11;

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // One access request
  typedef struct packed {
    logic             operation;
    logic [LEN_W-1:0] amount;
  } chfm_item_t;

  // One status report
  typedef struct packed {
    logic [IDX_OUT_W-1:0] read_chunk;
    logic [LEN_W-1:0]     read_offset;
    logic [LEN_W-1:0]     readable_len;
    logic [IDX_OUT_W-1:0] write_chunk;
    logic [LEN_W-1:0]     write_offset;
    logic [LEN_W-1:0]     writable_len;
    logic                 overrun;
  } chfm_result_t;

endpackage

>>> hdl/chfm_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chfm_in_stage
// Input register: captures one item and holds it until the core takes it.
// ----------------------------------------------------------------------------
module chfm_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  chfm_pkg::chfm_item_t in_item,
  input  logic               take_i,
  output logic               valid_o,
  output chfm_pkg::chfm_item_t item_o
);
  import chfm_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  chfm_item_t item_r;
  logic       accept;

  // Stall while a held item is not being taken this cycle
  assign in_stall = valid_r && !take_i;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take_i) begin
      valid_nxt = 1'b0;
    end
  end

  // Hold valid flag and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign valid_o = valid_r;
  assign item_o  = item_r;

endmodule

>>> hdl/chfm_ptr_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chfm_ptr_core
// Pointer state and update logic. Chunks from head up to the writer are
// full, the writer chunk holds wfill_r bytes and all others are empty, so
// only the writer fill needs storing.
// ----------------------------------------------------------------------------
module chfm_ptr_core #(
  parameter int unsigned N_CHUNKS    = 8,
  parameter int unsigned CHUNK_BYTES = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv_i,
  input  chfm_pkg::chfm_item_t   item_i,
  output chfm_pkg::chfm_result_t result_o
);
  import chfm_pkg::*;

  localparam int unsigned IW   = $clog2(N_CHUNKS);
  localparam int unsigned FW   = $clog2(CHUNK_BYTES + 1);
  localparam int unsigned CMPW = (FW > LEN_W) ? FW + 1 : LEN_W + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(N_CHUNKS - 1);
  localparam logic [FW-1:0] FULL     = FW'(CHUNK_BYTES);

  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] writer_r, writer_nxt;
  logic [FW-1:0] wfill_r, wfill_nxt;
  logic [FW-1:0] rpos_r, rpos_nxt;

  logic [IW-1:0]   tail_cur, tail_new;
  logic [FW-1:0]   hfill_cur, hfill_new;
  logic [FW-1:0]   rd_win_cur, wr_win_cur, rd_win_new, wr_win_new;
  logic [CMPW-1:0] amt_x, sum_x;
  logic            over;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
    ring_next = (i == LAST_IDX) ? '0 : IW'(i + 1'b1);
  endfunction

  function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] i);
    ring_prev = (i == '0) ? LAST_IDX : IW'(i - 1'b1);
  endfunction

  // Windows seen before the item
  always_comb begin
    tail_cur  = ring_prev(head_r);
    hfill_cur = (head_r == writer_r) ? wfill_r : FULL;
    if (head_r == writer_r && rpos_r == hfill_cur) begin
      rd_win_cur = '0;
    end else begin
      rd_win_cur = (hfill_cur >= rpos_r) ? FW'(hfill_cur - rpos_r) : '0;
    end
    if (writer_r == tail_cur && wfill_r == FULL) begin
      wr_win_cur = '0;
    end else begin
      wr_win_cur = FW'(FULL - wfill_r);
    end
  end

  // Apply push or pop, drop the item on overrun
  always_comb begin
    head_nxt   = head_r;
    writer_nxt = writer_r;
    wfill_nxt  = wfill_r;
    rpos_nxt   = rpos_r;
    over       = 1'b0;
    amt_x      = CMPW'(item_i.amount);
    sum_x      = '0;
    case (item_i.operation)
      OP_PUSH: begin
        if (amt_x > CMPW'(wr_win_cur)) begin
          over = 1'b1;
        end else begin
          sum_x     = CMPW'(wfill_r) + amt_x;
          wfill_nxt = FW'(sum_x);
          if (wfill_nxt == FULL && writer_r != tail_cur) begin
            writer_nxt = ring_next(writer_r);
            wfill_nxt  = '0;
          end
        end
      end
      OP_POP: begin
        if (amt_x > CMPW'(rd_win_cur)) begin
          over = 1'b1;
        end else begin
          sum_x    = CMPW'(rpos_r) + amt_x;
          rpos_nxt = FW'(sum_x);
          if (rpos_nxt == hfill_cur && head_r != writer_r) begin
            head_nxt = ring_next(head_r);
            rpos_nxt = '0;
          end
        end
      end
      default: begin
        over = 1'b0;
      end
    endcase
  end

  // Windows seen after the item
  always_comb begin
    tail_new  = ring_prev(head_nxt);
    hfill_new = (head_nxt == writer_nxt) ? wfill_nxt : FULL;
    if (head_nxt == writer_nxt && rpos_nxt == hfill_new) begin
      rd_win_new = '0;
    end else begin
      rd_win_new = (hfill_new >= rpos_nxt) ? FW'(hfill_new - rpos_nxt) : '0;
    end
    if (writer_nxt == tail_new && wfill_nxt == FULL) begin
      wr_win_new = '0;
    end else begin
      wr_win_new = FW'(FULL - wfill_nxt);
    end
  end

  // Build the report
  always_comb begin
    result_o.read_chunk   = IDX_OUT_W'(head_nxt);
    result_o.read_offset  = LEN_W'(rpos_nxt);
    result_o.readable_len = LEN_W'(rd_win_new);
    result_o.write_chunk  = IDX_OUT_W'(writer_nxt);
    result_o.write_offset = LEN_W'(wfill_nxt);
    result_o.writable_len = LEN_W'(wr_win_new);
    result_o.overrun      = over;
  end

  // Advance state when the item moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      writer_r <= '0;
      wfill_r  <= '0;
      rpos_r   <= '0;
    end else if (adv_i) begin
      head_r   <= head_nxt;
      writer_r <= writer_nxt;
      wfill_r  <= wfill_nxt;
      rpos_r   <= rpos_nxt;
    end
  end

  a_rpos_in_head: assert property (@(posedge clk) disable iff (!rst_n)
    rpos_r <= hfill_cur)
    else $error("read offset beyond head chunk fill");

  a_wfill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wfill_r <= FULL)
    else $error("writer fill beyond chunk size");

  a_push_keeps_head: assert property (@(posedge clk) disable iff (!rst_n)
    (adv_i && item_i.operation == OP_PUSH) |=> $stable(head_r) && $stable(rpos_r))
    else $error("push moved the read side");

endmodule

>>> hdl/chunked_byte_fifo_manager_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_byte_fifo_manager_unit
// Pointer manager for a byte FIFO built from a ring of fixed-size chunks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one push or pop item:
//   in_operation selects push (0) or pop (1), in_amount the byte count.
//   Result channel (out_valid / out_stall) returns one report per item with
//   the read window (head chunk, offset, readable bytes), the write window
//   (writer chunk, offset, free bytes) and an overrun flag. An amount larger
//   than the window is dropped and flagged; state stays as it was.
//   An accepted item passes the input register, then the result register,
//   before out_valid rises with its report.
//   Throughput: one item per cycle while out_stall is low, set by the
//   single pass of pointer update logic between the two registers.
//   Reset (rst_n low, synchronous) empties all chunks and clears head,
//   writer and read offset to zero; no valid items remain.
//   When out_stall is high the report is held; the item waiting in the
//   input register then holds too, and in_stall rises until the result
//   register drains.
// ----------------------------------------------------------------------------
module chunked_byte_fifo_manager_unit #(
  parameter int unsigned N_CHUNKS    = 8,
  parameter int unsigned CHUNK_BYTES = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic [chfm_pkg::LEN_W-1:0]     in_amount,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [chfm_pkg::IDX_OUT_W-1:0] out_read_chunk,
  output logic [chfm_pkg::LEN_W-1:0]     out_read_offset,
  output logic [chfm_pkg::LEN_W-1:0]     out_readable_len,
  output logic [chfm_pkg::IDX_OUT_W-1:0] out_write_chunk,
  output logic [chfm_pkg::LEN_W-1:0]     out_write_offset,
  output logic [chfm_pkg::LEN_W-1:0]     out_writable_len,
  output logic                           out_overrun
);
  import chfm_pkg::*;

  chfm_item_t   in_item;
  chfm_item_t   stage_item;
  logic         stage_valid;
  logic         adv;
  chfm_result_t core_result;
  chfm_result_t res_r;
  logic         out_valid_r, out_valid_nxt;

  assign in_item.operation = in_operation;
  assign in_item.amount    = in_amount;

  // Move an item on when the result register is free or draining
  assign adv = stage_valid && (!out_valid_r || !out_stall);

  chfm_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take_i   (adv),
    .valid_o  (stage_valid),
    .item_o   (stage_item)
  );

  chfm_ptr_core #(
    .N_CHUNKS    (N_CHUNKS),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_ptr_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv_i    (adv),
    .item_i   (stage_item),
    .result_o (core_result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= core_result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_chunk   = res_r.read_chunk;
  assign out_read_offset  = res_r.read_offset;
  assign out_readable_len = res_r.readable_len;
  assign out_write_chunk  = res_r.write_chunk;
  assign out_write_offset = res_r.write_offset;
  assign out_writable_len = res_r.writable_len;
  assign out_overrun      = res_r.overrun;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !adv)
    else $error("result overwritten while stalled");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced item not presented");

  a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_valid && out_valid_r && out_stall) |-> in_stall)
    else $error("input taken while pipeline blocked");

endmodule

>>> test/tb_chunked_byte_fifo_manager_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chunked_byte_fifo_manager_unit
// Self-checking bench for the chunked byte FIFO pointer manager. A local
// pointer model tracks chunk fills, head, writer and read offset, and
// computes the status report for every accepted push or pop. Reports from
// the block are checked in order, field by field. Stimulus covers corner
// sequences (overruns, full ring, drained head recycle), long random traffic
// that fills and drains the ring, a long receiver hold-off and a final
// back-to-back stretch.
// ----------------------------------------------------------------------------
module tb_chunked_byte_fifo_manager_unit;
  import chfm_pkg::*;

  localparam int unsigned N_CHUNKS    = 8;
  localparam int unsigned CHUNK_BYTES = 1024;
  localparam int unsigned AMOUNT_MAX  = (1 << LEN_W) - 1;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned SETTLE      = 10;

  logic                 clk;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic                 in_operation = 1'b0;
  logic [LEN_W-1:0]     in_amount    = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [IDX_OUT_W-1:0] out_read_chunk;
  logic [LEN_W-1:0]     out_read_offset;
  logic [LEN_W-1:0]     out_readable_len;
  logic [IDX_OUT_W-1:0] out_write_chunk;
  logic [LEN_W-1:0]     out_write_offset;
  logic [LEN_W-1:0]     out_writable_len;
  logic                 out_overrun;

  // Pointer model state
  int unsigned chunk_fill [N_CHUNKS];
  int unsigned head_idx;
  int unsigned wr_idx;
  int unsigned rd_pos;

  chfm_result_t pending_reports [$];
  int unsigned  errors    = 0;
  int unsigned  cycle_cnt = 0;

  // Idle control shared with the stall driver and the sender
  bit          tx_quiet  = 1'b0;
  bit          rx_quiet  = 1'b0;
  int unsigned hold_req  = 0;
  int unsigned hold_left = 0;
  int unsigned burst_left = 0;
  bit          burst_level = 1'b0;

  chunked_byte_fifo_manager_unit #(
    .N_CHUNKS   (N_CHUNKS),
    .CHUNK_BYTES(CHUNK_BYTES)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_amount       (in_amount),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_chunk  (out_read_chunk),
    .out_read_offset (out_read_offset),
    .out_readable_len(out_readable_len),
    .out_write_chunk (out_write_chunk),
    .out_write_offset(out_write_offset),
    .out_writable_len(out_writable_len),
    .out_overrun     (out_overrun)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
    $display("chunked_byte_fifo_manager_unit verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Pointer model
  // --------------------------------------------------------------------------
  function automatic int unsigned tail_idx();
    return (head_idx + N_CHUNKS - 1) % N_CHUNKS;
  endfunction

  // Bytes readable in the head chunk
  function automatic int unsigned read_window();
    if (head_idx == wr_idx && rd_pos == chunk_fill[head_idx]) return 0;
    return (chunk_fill[head_idx] >= rd_pos) ? chunk_fill[head_idx] - rd_pos : 0;
  endfunction

  // Free bytes in the writer chunk; zero once the tail chunk is full
  function automatic int unsigned write_window();
    if (wr_idx == tail_idx() && chunk_fill[wr_idx] == CHUNK_BYTES) return 0;
    return (CHUNK_BYTES >= chunk_fill[wr_idx]) ? CHUNK_BYTES - chunk_fill[wr_idx] : 0;
  endfunction

  function automatic void reset_pointers();
    foreach (chunk_fill[i]) chunk_fill[i] = 0;
    head_idx = 0;
    wr_idx   = 0;
    rd_pos   = 0;
  endfunction

  // Apply one access and return the status report it produces
  function automatic chfm_result_t update_pointers(logic op, logic [LEN_W-1:0] amt);
    chfm_result_t rep;
    logic         over;
    over = 1'b0;
    if (op == OP_PUSH) begin
      if (amt > write_window()) begin
        over = 1'b1;
      end else begin
        chunk_fill[wr_idx] += amt;
        if (chunk_fill[wr_idx] == CHUNK_BYTES && wr_idx != tail_idx())
          wr_idx = (wr_idx + 1) % N_CHUNKS;
      end
    end else begin
      if (amt > read_window()) begin
        over = 1'b1;
      end else begin
        rd_pos += amt;
        // Recycle a drained head chunk to the tail
        if (rd_pos == chunk_fill[head_idx] && head_idx != wr_idx) begin
          chunk_fill[head_idx] = 0;
          head_idx = (head_idx + 1) % N_CHUNKS;
          rd_pos   = 0;
        end
      end
    end
    rep.read_chunk   = IDX_OUT_W'(head_idx);
    rep.read_offset  = LEN_W'(rd_pos);
    rep.readable_len = LEN_W'(read_window());
    rep.write_chunk  = IDX_OUT_W'(wr_idx);
    rep.write_offset = LEN_W'(chunk_fill[wr_idx]);
    rep.writable_len = LEN_W'(write_window());
    rep.overrun      = over;
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : report_check
    chfm_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: report with none expected, expected none, got chunk %0d/%0d",
                 $time, out_read_chunk, out_write_chunk);
      end else begin
        want = pending_reports.pop_front();
        check_field("read_chunk",   16'(want.read_chunk),   16'(out_read_chunk));
        check_field("read_offset",  16'(want.read_offset),  16'(out_read_offset));
        check_field("readable_len", 16'(want.readable_len), 16'(out_readable_len));
        check_field("write_chunk",  16'(want.write_chunk),  16'(out_write_chunk));
        check_field("write_offset", 16'(want.write_offset), 16'(out_write_offset));
        check_field("writable_len", 16'(want.writable_len), 16'(out_writable_len));
        check_field("overrun",      16'(want.overrun),      16'(out_overrun));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall: long hold on request, else random bursts or none
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : stall_driver
    logic nxt;
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      nxt = 1'b1;
    end else if (rx_quiet) begin
      nxt = 1'b0;
    end else begin
      if (burst_left == 0) begin
        burst_left  = $urandom_range(1, 12);
        burst_level = ($urandom_range(0, 9) < 4);
      end
      burst_left--;
      nxt = burst_level;
    end
    out_stall <= nxt;
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  // Offer one item, wait for acceptance, then record its expected report
  task automatic send_item(logic op, logic [LEN_W-1:0] amt);
    int unsigned gap;
    if (!tx_quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid     <= 1'b0;
      in_operation <= 1'($urandom);
      in_amount    <= LEN_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_amount    <= amt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_reports.push_back(update_pointers(op, amt));
  endtask

  // Pick an amount around the current window; some overrun on purpose
  function automatic logic [LEN_W-1:0] pick_amount(int unsigned window);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6)  return '0;
    if (r < 18) return LEN_W'(window);
    if (r < 24) return LEN_W'(window + 1);
    if (r < 30) return LEN_W'($urandom_range(window + 1, AMOUNT_MAX));
    if (r < 34) return LEN_W'($urandom);
    if (r < 60) return LEN_W'($urandom_range(0, (window < 16) ? window : 16));
    return LEN_W'($urandom_range(0, window));
  endfunction

  task automatic send_random(int unsigned push_pct);
    logic             op;
    logic [LEN_W-1:0] amt;
    op  = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
    amt = pick_amount((op == OP_PUSH) ? write_window() : read_window());
    send_item(op, amt);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Overruns, chunk hand-over, drained head recycle, full ring
  task automatic test_directed_corners();
    send_item(OP_PUSH, '0);
    send_item(OP_POP,  '0);
    send_item(OP_POP,  LEN_W'(1));                 // pop on empty
    send_item(OP_PUSH, LEN_W'(AMOUNT_MAX));        // far over window
    send_item(OP_PUSH, LEN_W'(CHUNK_BYTES + 1));
    send_item(OP_PUSH, LEN_W'(CHUNK_BYTES));       // fill chunk 0, writer moves
    send_item(OP_POP,  LEN_W'(CHUNK_BYTES + 1));
    send_item(OP_POP,  LEN_W'(CHUNK_BYTES));       // drain and recycle head
    send_item(OP_PUSH, LEN_W'(512));
    send_item(OP_POP,  LEN_W'(512));               // head is writer, fully read
    send_item(OP_PUSH, LEN_W'(512));               // fills the drained head
    send_item(OP_POP,  '0);                        // zero pop, head half read
    // Fill every chunk until the ring is full
    repeat (N_CHUNKS) send_item(OP_PUSH, LEN_W'(CHUNK_BYTES));
    send_item(OP_PUSH, LEN_W'(1));
    send_item(OP_PUSH, '0);
    send_item(OP_POP,  LEN_W'(512));               // free one chunk
    send_item(OP_PUSH, '0);                        // zero push moves writer on
    send_item(OP_POP,  LEN_W'(AMOUNT_MAX));
  endtask

  // Alternate fill-heavy and drain-heavy phases so the ring wraps often
  task automatic test_random_traffic(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_random(((i / 150) % 2 == 0) ? 75 : 25);
    end
  endtask

  // Hold the receiver off while items keep coming so the input stalls
  task automatic test_backpressure(int unsigned count);
    tx_quiet = 1'b1;
    hold_req = 150;
    repeat (count) send_random(50);
    tx_quiet = 1'b0;
  endtask

  // Back-to-back items with no idling on either side
  task automatic test_streaming(int unsigned count);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    for (int unsigned i = 0; i < count; i++) begin
      send_random(((i / 60) % 2 == 0) ? 70 : 30);
    end
  endtask

  initial begin
    reset_pointers();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_random_traffic(1600);
    test_backpressure(60);
    test_streaming(240);

    // Drain outstanding reports, then let the pipeline settle
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (errors == 0 && pending_reports.size() == 0) begin
      $display("chunked_byte_fifo_manager_unit verification clean");
    end else begin
      $display("chunked_byte_fifo_manager_unit verification failed");
    end
    $finish;
  end

endmodule
